### hdl/rwcd_pkg.sv
// shared constants and widths for the rgb555 weighted color distance block
`default_nettype none

package rwcd_pkg;

    // color packing
    localparam int COLOR_W = 15;
    localparam int CHAN_W  = 5;
    localparam int RED_LO  = 10;
    localparam int GRN_LO  = 5;
    localparam int BLU_LO  = 0;

    // intermediate widths
    localparam int RSUM_W = CHAN_W + 1;     // ra + rb, 0..62
    localparam int SQ_W   = 2 * CHAN_W;     // channel difference squared
    localparam int WGT_W  = 8;              // red and blue weights, up to 186
    localparam int PROD_W = 18;             // weight times square, up to 238328
    localparam int N_W    = 20;             // weighted sum, up to 595820
    localparam int CODE_W = 8;

    // channel weights, scaled so the sum is exact
    localparam logic [WGT_W-1:0] RED_BASE     = 8'd124;
    localparam logic [WGT_W-1:0] BLUE_BASE    = 8'd186;
    localparam logic [WGT_W-1:0] GREEN_WEIGHT = 8'd248;

    // code = round(n * SCALE_NUM / SCALE_DEN), saturated
    localparam longint unsigned SCALE_NUM = 64'd28333;
    localparam longint unsigned SCALE_DEN = 64'd59582000;
    localparam longint unsigned HALF_DEN  = SCALE_DEN / 64'd2;

    // reciprocal estimate, floor so the estimate never overshoots
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 21;
    localparam longint unsigned RECIP_FULL =
        (SCALE_NUM << RECIP_SHIFT) / SCALE_DEN;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_EST_W = N_W + RECIP_W;   // 41 bits

    // exact numerator and estimate widths
    localparam int NUM_W = 35;
    localparam int EST_W = 10;                   // estimate plus one, up to 284

    localparam logic [EST_W-1:0] CODE_MAX = 10'd255;

endpackage

`default_nettype wire

### hdl/rgb555_weighted_color_distance.sv
// top level of the rgb555 redmean weighted color distance pipeline
//
// usage:
//   a beat is two RGB555 colors on first_color and second_color (red in
//   bits 14:10, green 9:5, blue 4:0). raise start for one cycle per beat;
//   the beat is taken at the rising edge where start is high and busy is
//   low. busy is never raised, so a new beat can be taken every cycle.
//   the result beat is distance_code, shown for exactly one cycle with
//   done high, after the input beat has passed through the eight register
//   stages: differences, squares, weighted products, sum, reciprocal
//   multiply, rounding estimate, next-code bound, correct and saturate.
//   results leave in input order. every stage advances each cycle, so
//   throughput is one beat per cycle; the receiver cannot stall, so no
//   stage ever holds.
//   reset clears all valid bits; beats in flight are dropped and done
//   stays low until a new beat comes through.
//   distance_code = round_half_up(n * 28333 / 59582000), saturated at 255,
//   with n = (124+ra+rb)*dr^2 + 248*dg^2 + (186-ra-rb)*db^2.
`default_nettype none

module rgb555_weighted_color_distance (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [rwcd_pkg::COLOR_W-1:0] first_color,
    input  wire logic [rwcd_pkg::COLOR_W-1:0] second_color,
    output logic                              done,
    output logic [rwcd_pkg::CODE_W-1:0]       distance_code
);
    import rwcd_pkg::*;

    logic           in_valid;
    logic           n_valid;
    logic [N_W-1:0] n_value;

    // the pipeline takes a beat every cycle
    assign busy     = 1'b0;
    assign in_valid = start & ~busy;

    // weighted squared sum
    rwcd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .first_color  (first_color),
        .second_color (second_color),
        .n_valid      (n_valid),
        .n_value      (n_value)
    );

    // scale, round and saturate
    rwcd_quant u_quant (
        .clk        (clk),
        .rst_n      (rst_n),
        .n_valid    (n_valid),
        .n_value    (n_value),
        .code_valid (done),
        .code       (distance_code)
    );

endmodule

`default_nettype wire

### hdl/rwcd_front.sv
// front pipeline: channel differences, squares, weighted products and their sum
`default_nettype none

module rwcd_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [rwcd_pkg::COLOR_W-1:0] first_color,
    input  wire logic [rwcd_pkg::COLOR_W-1:0] second_color,
    output logic                             n_valid,
    output logic [rwcd_pkg::N_W-1:0]         n_value
);
    import rwcd_pkg::*;

    logic [CHAN_W-1:0] ra, ga, ba, rb, gb, bb;

    // stage 1: absolute differences and red sum
    logic [CHAN_W-1:0] dr_next, dg_next, db_next;
    logic [RSUM_W-1:0] rsum_next;
    logic [CHAN_W-1:0] dr_reg, dg_reg, db_reg;
    logic [RSUM_W-1:0] rsum_reg;
    logic              v1_reg;

    // stage 2: squares and weights
    logic [SQ_W-1:0]  sqr_next, sqg_next, sqb_next;
    logic [WGT_W-1:0] wr_next, wb_next;
    logic [SQ_W-1:0]  sqr_reg, sqg_reg, sqb_reg;
    logic [WGT_W-1:0] wr_reg, wb_reg;
    logic             v2_reg;

    // stage 3: weighted products
    logic [PROD_W-1:0] pr_next, pg_next, pb_next;
    logic [PROD_W-1:0] pr_reg, pg_reg, pb_reg;
    logic              v3_reg;

    // stage 4: sum
    logic [N_W-1:0] n_next;
    logic [N_W-1:0] n_reg;
    logic           v4_reg;

    // unpack both colors
    always_comb
    begin
        ra = first_color[RED_LO +: CHAN_W];
        ga = first_color[GRN_LO +: CHAN_W];
        ba = first_color[BLU_LO +: CHAN_W];
        rb = second_color[RED_LO +: CHAN_W];
        gb = second_color[GRN_LO +: CHAN_W];
        bb = second_color[BLU_LO +: CHAN_W];
    end

    // stage 1 logic
    always_comb
    begin
        dr_next   = (ra > rb) ? (ra - rb) : (rb - ra);
        dg_next   = (ga > gb) ? (ga - gb) : (gb - ga);
        db_next   = (ba > bb) ? (ba - bb) : (bb - ba);
        rsum_next = {1'b0, ra} + {1'b0, rb};
    end

    // stage 2 logic
    always_comb
    begin
        sqr_next = SQ_W'(dr_reg) * SQ_W'(dr_reg);
        sqg_next = SQ_W'(dg_reg) * SQ_W'(dg_reg);
        sqb_next = SQ_W'(db_reg) * SQ_W'(db_reg);
        wr_next  = RED_BASE + WGT_W'(rsum_reg);
        wb_next  = BLUE_BASE - WGT_W'(rsum_reg);
    end

    // stage 3 logic
    always_comb
    begin
        pr_next = PROD_W'(wr_reg) * PROD_W'(sqr_reg);
        pg_next = PROD_W'(GREEN_WEIGHT) * PROD_W'(sqg_reg);
        pb_next = PROD_W'(wb_reg) * PROD_W'(sqb_reg);
    end

    // stage 4 logic
    always_comb
    begin
        n_next = N_W'(pr_reg) + N_W'(pg_reg) + N_W'(pb_reg);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        dr_reg   <= dr_next;
        dg_reg   <= dg_next;
        db_reg   <= db_next;
        rsum_reg <= rsum_next;
        sqr_reg  <= sqr_next;
        sqg_reg  <= sqg_next;
        sqb_reg  <= sqb_next;
        wr_reg   <= wr_next;
        wb_reg   <= wb_next;
        pr_reg   <= pr_next;
        pg_reg   <= pg_next;
        pb_reg   <= pb_next;
        n_reg    <= n_next;
    end

    assign n_valid = v4_reg;
    assign n_value = n_reg;

endmodule

`default_nettype wire

### hdl/rwcd_quant.sv
// back pipeline: scales the weighted sum to a rounded, saturated 8-bit code
`default_nettype none

module rwcd_quant (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     n_valid,
    input  wire logic [rwcd_pkg::N_W-1:0] n_value,
    output logic                          code_valid,
    output logic [rwcd_pkg::CODE_W-1:0]   code
);
    import rwcd_pkg::*;

    // stage a: reciprocal product and exact numerator product
    logic [PROD_EST_W-1:0] pe_next, pe_reg;
    logic [NUM_W-1:0]      xp_next, xp_reg;
    logic                  va_reg;

    // stage b: estimate (floor of rounded quotient, low by at most one)
    logic [PROD_EST_W-1:0] pe_round;
    logic [EST_W-1:0]      est_next, est_b_reg;
    logic [NUM_W-1:0]      x_next, x_b_reg;
    logic                  vb_reg;

    // stage c: bound for the next code up
    logic [EST_W-1:0] est1;
    logic [NUM_W-1:0] m_next, m_reg;
    logic [EST_W-1:0] est_c_reg;
    logic [NUM_W-1:0] x_c_reg;
    logic             vc_reg;

    // stage d: correction and saturation
    logic [EST_W-1:0]  q;
    logic [CODE_W-1:0] code_next, code_reg;
    logic              vd_reg;

    // stage a logic
    always_comb
    begin
        pe_next = PROD_EST_W'(n_value) * PROD_EST_W'(RECIP);
        xp_next = NUM_W'(n_value) * NUM_W'(SCALE_NUM);
    end

    // stage b logic
    always_comb
    begin
        pe_round = pe_reg + (PROD_EST_W'(1) << (RECIP_SHIFT - 1));
        est_next = EST_W'(pe_round >> RECIP_SHIFT);
        x_next   = xp_reg + NUM_W'(HALF_DEN);
    end

    // stage c logic
    always_comb
    begin
        est1   = est_b_reg + EST_W'(1);
        m_next = NUM_W'(est1) * NUM_W'(SCALE_DEN);
    end

    // stage d logic
    always_comb
    begin
        q = (x_c_reg >= m_reg) ? (est_c_reg + EST_W'(1)) : est_c_reg;
        if (q > CODE_MAX)
            code_next = CODE_MAX[CODE_W-1:0];
        else
            code_next = q[CODE_W-1:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= n_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // data registers
    always_ff @(posedge clk)
    begin
        pe_reg    <= pe_next;
        xp_reg    <= xp_next;
        est_b_reg <= est_next;
        x_b_reg   <= x_next;
        m_reg     <= m_next;
        est_c_reg <= est_b_reg;
        x_c_reg   <= x_b_reg;
        code_reg  <= code_next;
    end

    assign code_valid = vd_reg;
    assign code       = code_reg;

endmodule

`default_nettype wire

### dv/tb.sv
// testbench for the rgb555 weighted color distance block: directed rows, then random pairs
`timescale 1ns / 100ps

module tb;

    import rwcd_pkg::*;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [CODE_W-1:0]  code_t;

    // directed stimulus row; code is only used when it is typed in
    typedef struct {
        color_t a;
        color_t b;
        bit     typed;
        code_t  code;
    } pair_row_t;

    localparam int           CYCLE_LIMIT   = 200000;
    localparam int           DRAIN_CYCLES  = 20;
    localparam int           PAIRS_PER_SET = 200;
    localparam longint unsigned DIST_NUM   = 28333;
    localparam longint unsigned DIST_DEN   = 59582000;
    localparam longint unsigned CODE_CEIL  = 255;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    color_t first_color;
    color_t second_color;
    logic   done;
    code_t  distance_code;

    code_t  expected_codes[$];
    int     fail_count;
    int     cycle_count;

    rgb555_weighted_color_distance u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .first_color   (first_color),
        .second_color  (second_color),
        .done          (done),
        .distance_code (distance_code)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // redmean weighted squared distance, scaled, rounded half up, saturated
    function automatic code_t predict_distance_code(input color_t a, input color_t b);
        longint unsigned red_a, red_b, grn_a, grn_b, blu_a, blu_b;
        longint unsigned red_sum, d_red, d_grn, d_blu, weighted, rounded;
        red_a = a[RED_LO +: CHAN_W];
        red_b = b[RED_LO +: CHAN_W];
        grn_a = a[GRN_LO +: CHAN_W];
        grn_b = b[GRN_LO +: CHAN_W];
        blu_a = a[BLU_LO +: CHAN_W];
        blu_b = b[BLU_LO +: CHAN_W];
        red_sum = red_a + red_b;
        d_red = (red_a > red_b) ? red_a - red_b : red_b - red_a;
        d_grn = (grn_a > grn_b) ? grn_a - grn_b : grn_b - grn_a;
        d_blu = (blu_a > blu_b) ? blu_a - blu_b : blu_b - blu_a;
        weighted = (124 + red_sum) * d_red * d_red
                 + 248 * d_grn * d_grn
                 + (186 - red_sum) * d_blu * d_blu;
        rounded = (weighted * DIST_NUM + DIST_DEN / 2) / DIST_DEN;
        if (rounded > CODE_CEIL)
            rounded = CODE_CEIL;
        return rounded[CODE_W-1:0];
    endfunction

    // nudge one channel by a small signed step, clamped to the channel range
    function automatic chan_t nudge_channel(input chan_t ch, input int step);
        int v;
        v = int'(ch) + step;
        if (v < 0)
            v = 0;
        if (v > 31)
            v = 31;
        return chan_t'(v);
    endfunction

    // second color of a random pair, shaped by the chosen kind
    function automatic color_t partner_color(input color_t a);
        int    kind;
        chan_t r, g, bl;
        kind = $urandom_range(9);
        r  = a[RED_LO +: CHAN_W];
        g  = a[GRN_LO +: CHAN_W];
        bl = a[BLU_LO +: CHAN_W];
        if (kind <= 3)
            return color_t'($urandom_range(32767));
        if (kind <= 6)
        begin
            // close colors, codes near the low end and near rounding edges
            r  = nudge_channel(r, int'($urandom_range(6)) - 3);
            g  = nudge_channel(g, int'($urandom_range(6)) - 3);
            bl = nudge_channel(bl, int'($urandom_range(6)) - 3);
            return {r, g, bl};
        end
        if (kind == 7)
            return a;
        // channel-wise complement, large distances near the top code
        return {~r, ~g, ~bl} ^ color_t'($urandom_range(3));
    endfunction

    // present one beat, wait for it to be taken and queue its expected code
    task automatic send_pair(input color_t a, input color_t b, input int gap_pct,
                             input bit typed, input code_t code);
        while (int'($urandom_range(99)) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        first_color  <= a;
        second_color <= b;
        do
            @(posedge clk);
        while (busy);
        expected_codes.insert(expected_codes.size(),
                              typed ? code : predict_distance_code(a, b));
    endtask

    // wait until every queued code has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_codes.size() != 0)
            @(posedge clk);
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_codes.size() == 0)
            begin
                $error("distance_code: unexpected result %0d", distance_code);
                fail_count++;
            end
            else
            begin
                if (distance_code !== expected_codes[0])
                begin
                    $error("distance_code: expected %0d, actual %0d",
                           expected_codes[0], distance_code);
                    fail_count++;
                end
                void'(expected_codes.pop_front());
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("rgb555_weighted_color_distance: mismatch");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        // equal colors give 0, black against white gives the top code 255;
        // no weighted sum lands on an exact half, so ties never occur
        pair_row_t rows[] = '{
            '{15'h0000, 15'h0000, 1'b1, 8'd0},
            '{15'h7FFF, 15'h7FFF, 1'b1, 8'd0},
            '{15'h1234, 15'h1234, 1'b1, 8'd0},
            '{15'h0000, 15'h7FFF, 1'b1, 8'd255},
            '{15'h7FFF, 15'h0000, 1'b1, 8'd255},
            '{15'h7C00, 15'h0000, 1'b0, 8'd0},
            '{15'h0000, 15'h7C00, 1'b0, 8'd0},
            '{15'h03E0, 15'h0000, 1'b0, 8'd0},
            '{15'h001F, 15'h0000, 1'b0, 8'd0},
            '{15'h7C00, 15'h001F, 1'b0, 8'd0},
            '{15'h03E0, 15'h7C1F, 1'b0, 8'd0},
            '{15'h0001, 15'h0000, 1'b0, 8'd0},
            '{15'h7C00, 15'h7C01, 1'b0, 8'd0},
            '{15'h0020, 15'h0000, 1'b0, 8'd0},
            '{15'h0400, 15'h0000, 1'b0, 8'd0},
            '{15'h5555, 15'h2AAA, 1'b0, 8'd0},
            '{15'h2AAA, 15'h5555, 1'b0, 8'd0},
            '{15'h4210, 15'h0000, 1'b0, 8'd0},
            '{15'h7FE0, 15'h001F, 1'b0, 8'd0},
            '{15'h7C1F, 15'h03E0, 1'b0, 8'd0}
        };
        color_t a;
        int     gap_pct;

        rst_n        = 1'b0;
        start        = 1'b0;
        first_color  = '0;
        second_color = '0;
        fail_count   = 0;
        cycle_count  = 0;

        // reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (rows[i])
            send_pair(rows[i].a, rows[i].b, 0, rows[i].typed, rows[i].code);
        wait_drained();

        // random pairs: sender idles rarely, then often, then never
        for (int set = 0; set < 3; set++)
        begin
            gap_pct = (set == 0) ? 9 : (set == 1) ? 51 : 0;
            for (int i = 0; i < PAIRS_PER_SET; i++)
            begin
                a = color_t'($urandom_range(32767));
                if ($urandom_range(1))
                    send_pair(a, partner_color(a), gap_pct, 1'b0, '0);
                else
                    send_pair(partner_color(a), a, gap_pct, 1'b0, '0);
            end
            // after the first set, hold off until the pipeline has emptied
            if (set == 0)
                wait_drained();
        end

        // end of run
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("rgb555_weighted_color_distance: match");
        else
            $display("rgb555_weighted_color_distance: mismatch");
        $finish;
    end

endmodule
